### hw/rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// shared widths, codes and the interpolation term program of the sampler
// ----------------------------------------------------------------------------
package kts_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int KIDX_W    = $clog2(MAX_KEYS);
	localparam int KCNT_W    = KIDX_W + 1;
	localparam int VAL_WORDS = 9 * MAX_KEYS;
	localparam int VADDR_W   = $clog2(VAL_WORDS);
	localparam int DATA_W    = 32;
	localparam int MAG_W     = DATA_W + 1;
	localparam int TN_W      = 17;
	localparam int H_W       = 20;
	localparam int COEF_W    = 34;
	localparam int PROD_W    = DATA_W + COEF_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int CFG_W     = 17;
	localparam int CFG_IDX_W = 2;

	localparam logic [TN_W-1:0] TN_ONE = TN_W'(65536);

	typedef enum logic [1:0] {
		ACT_KEY_TIME  = 2'd0,
		ACT_KEY_VALUE = 2'd1,
		ACT_SAMPLE    = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_COUNT    = 2'd0,
		REG_INTERP_MODE  = 2'd1,
		REG_BLEND_AMOUNT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_STEP   = 2'd0,
		MODE_LINEAR = 2'd1,
		MODE_CUBIC  = 2'd2,
		MODE_PASS   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_MEM = 3'd0,
		OP_A   = 3'd1,
		OP_B   = 3'd2,
		OP_S   = 3'd3,
		OP_CUR = 3'd4
	} opnd_t;

	typedef enum logic [2:0] {
		AD_P3   = 3'd0,
		AD_N3   = 3'd1,
		AD_TIN  = 3'd2,
		AD_TOUT = 3'd3,
		AD_V0   = 3'd4,
		AD_V1   = 3'd5
	} addr_t;

	typedef enum logic [3:0] {
		CF_ONE   = 4'd0,
		CF_OMT   = 4'd1,
		CF_TN    = 4'd2,
		CF_DELTA = 4'd3,
		CF_H00   = 4'd4,
		CF_H10   = 4'd5,
		CF_H01   = 4'd6,
		CF_H11   = 4'd7,
		CF_OMW   = 4'd8,
		CF_W     = 4'd9
	} coef_t;

	typedef enum logic [2:0] {
		DS_NONE = 3'd0,
		DS_A    = 3'd1,
		DS_B    = 3'd2,
		DS_S    = 3'd3,
		DS_OUT  = 3'd4
	} dest_t;

	typedef struct packed {
		opnd_t src;
		addr_t addr;
		coef_t coef;
		dest_t dest;
		logic  last;
	} term_t;

	// one product per step; a term with a destination closes its sum
	function automatic term_t term_of(mode_t mode, logic [2:0] step);
		term_t t;
		logic [2:0] nb;
		t = '{OP_CUR, AD_P3, CF_ONE, DS_NONE, 1'b0};
		nb = 3'd1;
		case (mode)
			MODE_STEP: begin
				nb = 3'd1;
				if (step == 3'd0) t = '{OP_MEM, AD_P3, CF_ONE, DS_S, 1'b0};
			end
			MODE_LINEAR: begin
				nb = 3'd2;
				if (step == 3'd0) t = '{OP_MEM, AD_P3, CF_OMT, DS_NONE, 1'b0};
				if (step == 3'd1) t = '{OP_MEM, AD_N3, CF_TN, DS_S, 1'b0};
			end
			MODE_CUBIC: begin
				nb = 3'd6;
				case (step)
					3'd0: t = '{OP_MEM, AD_TIN, CF_DELTA, DS_A, 1'b0};
					3'd1: t = '{OP_MEM, AD_TOUT, CF_DELTA, DS_B, 1'b0};
					3'd2: t = '{OP_MEM, AD_V0, CF_H00, DS_NONE, 1'b0};
					3'd3: t = '{OP_B, AD_P3, CF_H10, DS_NONE, 1'b0};
					3'd4: t = '{OP_MEM, AD_V1, CF_H01, DS_NONE, 1'b0};
					3'd5: t = '{OP_A, AD_P3, CF_H11, DS_S, 1'b0};
					default: ;
				endcase
			end
			default: begin
				nb = 3'd1;
				if (step == 3'd0) t = '{OP_CUR, AD_P3, CF_ONE, DS_S, 1'b0};
			end
		endcase
		if (step == nb) t = '{OP_CUR, AD_P3, CF_OMW, DS_NONE, 1'b0};
		if (step == nb + 3'd1) t = '{OP_S, AD_P3, CF_W, DS_OUT, 1'b1};
		return t;
	endfunction

endpackage

### hw/rtl/kts_div.sv
// ----------------------------------------------------------------------------
// kts_div
// restoring divider for normalised time, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kts_div import kts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MAG_W-1:0] num,
	input  logic [MAG_W-1:0] den,
	output logic             done,
	output logic [TN_W-1:0]  quo
);

	localparam int REM_W = MAG_W + 1;
	localparam int CNT_W = $clog2(TN_W + 1);

	logic             run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic [MAG_W-1:0] den_q;
	logic [TN_W-1:0]  q_q;
	logic             ovf_q;
	logic             ge;
	logic [REM_W-1:0] diff;

	assign ge   = rem_q >= {1'b0, den_q};
	assign diff = ge ? rem_q - {1'b0, den_q} : rem_q;
	assign done = run_q && (cnt_q == '0);
	assign quo  = (ovf_q || (q_q > TN_ONE)) ? TN_ONE : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(TN_W);
		end else if (run_q) begin
			if (cnt_q == '0) run_q <= 1'b0;
			else cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			q_q   <= '0;
			// quotient of two or more cannot fit, result clamps to one
			ovf_q <= {1'b0, num} >= {den, 1'b0};
		end else if (run_q && (cnt_q != '0)) begin
			rem_q <= {diff[REM_W-2:0], 1'b0};
			q_q   <= {q_q[TN_W-2:0], ge};
		end
	end

endmodule

### hw/rtl/keyframe_track_sampler.sv
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// Samples a three-component keyframe track. A beat with start high while busy
// is low is taken. Key-time and value-word writes complete in that same cycle
// and keep busy low. A sample beat raises busy and runs a small sequencer over
// one shared 32x34 multiplier and accumulator: two key-time reads, a clamp, a
// linear key search at one key per cycle, a bit-serial divide for normalised
// time (17 quotient bits), squaring and cubing, then the product terms of
// each component one at a time (step 3, linear 4, cubic 8 terms, plus one
// flush). How long a sample runs is set mainly by the key search and the
// shared multiplier. The result appears on out_x/out_y/out_z with done high
// for exactly one cycle and is not held: the receiver cannot stall, so it
// must take the beat when done is seen. Configuration must be written by the
// user through cfg_we/cfg_index/cfg_data only while idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module keyframe_track_sampler import kts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic [1:0]            action,
	input  logic [5:0]            key_index,
	input  logic [9:0]            word_address,
	input  logic signed [31:0]    write_value,
	input  logic signed [31:0]    sample_time,
	input  logic signed [31:0]    current_x,
	input  logic signed [31:0]    current_y,
	input  logic signed [31:0]    current_z,
	output logic signed [31:0]    out_x,
	output logic signed [31:0]    out_y,
	output logic signed [31:0]    out_z
);

	typedef enum logic [16:0] {
		ST_IDLE  = 17'h00001,
		ST_RD0   = 17'h00002,
		ST_RDL   = 17'h00004,
		ST_CLAMP = 17'h00008,
		ST_SRCH  = 17'h00010,
		ST_RDP   = 17'h00020,
		ST_RDN   = 17'h00040,
		ST_DELTA = 17'h00080,
		ST_DIV   = 17'h00100,
		ST_SQ    = 17'h00200,
		ST_SQR   = 17'h00400,
		ST_CU    = 17'h00800,
		ST_CUR   = 17'h01000,
		ST_HERM  = 17'h02000,
		ST_TA    = 17'h04000,
		ST_TB    = 17'h08000,
		ST_FLUSH = 17'h10000
	} state_t;

	// round half up from Q36.32 to Q16.16 and saturate to 32 bits
	function automatic logic signed [DATA_W-1:0] rsat(logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] r;
		r = (x + $signed(ACC_W'(32768))) >>> 16;
		if ((r[ACC_W-1:DATA_W-1] == '0) || (r[ACC_W-1:DATA_W-1] == '1))
			return r[DATA_W-1:0];
		return r[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

	// rounding of a lone product, used for the powers of tn
	function automatic logic signed [DATA_W-1:0] acc_rs_of(logic signed [PROD_W-1:0] p);
		return rsat(ACC_W'(p));
	endfunction

	// configuration
	logic [KCNT_W-1:0] key_count_q;
	mode_t             mode_q;
	logic [CFG_W-1:0]  blend_q;

	// sequencer
	state_t            state_q;
	logic              accept;
	logic [KCNT_W-1:0] k_q;
	logic [KIDX_W-1:0] si_q;
	logic              sv_q;
	logic [2:0]        step_q;
	logic [1:0]        comp_q;
	logic              pend_q;
	dest_t             pend_dest_q;
	logic              done_q;

	// datapath
	logic signed [DATA_W-1:0] t_q, tc_q, t0_q, tprev_q;
	logic signed [DATA_W-1:0] cur_q [3];
	logic signed [DATA_W-1:0] res_q [3];
	logic signed [DATA_W-1:0] a_q, b_q, s_q;
	logic [KIDX_W-1:0]        prev_q, next_q;
	logic signed [MAG_W-1:0]  delta_q;
	logic [TN_W-1:0]          tn_q, t2_q, t3_q;
	logic signed [H_W-1:0]    h00_q, h10_q, h01_q, h11_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;

	// stores
	logic [DATA_W-1:0] key_times_mem  [MAX_KEYS];
	logic [DATA_W-1:0] key_values_mem [VAL_WORDS];
	logic [DATA_W-1:0] times_rdata_q, values_rdata_q;
	logic [KIDX_W-1:0] time_raddr;
	logic [VADDR_W-1:0] value_raddr;

	logic [KCNT_W-1:0]        n_keys;
	logic [KIDX_W-1:0]        n_last;
	logic signed [DATA_W-1:0] trd;
	logic signed [MAG_W-1:0]  dnum, dden;
	logic [MAG_W-1:0]         div_num, div_den;
	logic                     tz;
	logic                     div_done;
	logic [TN_W-1:0]          div_quo;
	logic                     hit;
	logic [KIDX_W-1:0]        nx_hit;
	term_t                    term;
	logic [VADDR_W-1:0]       prev3, next3, prev9, next9, cext;
	logic signed [DATA_W-1:0] mul_a, opnd;
	logic signed [COEF_W-1:0] mul_b, coef;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [DATA_W-1:0] acc_rs;
	logic [TN_W-1:0]          w_eff;
	logic signed [H_W-1:0]    e1, e2, e3;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign out_x  = res_q[0];
	assign out_y  = res_q[1];
	assign out_z  = res_q[2];

	// keys in use, held to one through the store depth
	always_comb begin
		if (key_count_q == '0) n_keys = KCNT_W'(1);
		else if (key_count_q > KCNT_W'(MAX_KEYS)) n_keys = KCNT_W'(MAX_KEYS);
		else n_keys = key_count_q;
	end
	assign n_last = KIDX_W'(n_keys - 1'b1);

	assign w_eff = (blend_q > CFG_W'(TN_ONE)) ? TN_ONE : TN_W'(blend_q);
	assign trd   = $signed(times_rdata_q);

	// key-time read port address per sequencer step
	always_comb begin
		case (state_q)
			ST_RD0:  time_raddr = '0;
			ST_RDL:  time_raddr = n_last;
			ST_SRCH: time_raddr = k_q[KIDX_W-1:0];
			ST_RDP:  time_raddr = prev_q;
			ST_RDN:  time_raddr = next_q;
			default: time_raddr = '0;
		endcase
	end

	// interval and normalised-time operands, tprev held, next key on the port
	assign dnum = MAG_W'(tc_q) - MAG_W'(tprev_q);
	assign dden = MAG_W'(trd) - MAG_W'(tprev_q);
	assign tz   = (dden == '0) || (dnum == '0) || (dnum[MAG_W-1] != dden[MAG_W-1]);
	assign div_num = dnum[MAG_W-1] ? MAG_W'(-dnum) : MAG_W'(dnum);
	assign div_den = dden[MAG_W-1] ? MAG_W'(-dden) : MAG_W'(dden);

	kts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DELTA),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// search hit on the key whose time is on the read port
	assign hit    = sv_q && (trd >= tc_q);
	assign nx_hit = (si_q == '0) ? KIDX_W'(1) : si_q;

	// term program and value-store address
	assign term  = term_of(mode_q, step_q);
	assign prev3 = VADDR_W'(prev_q) + (VADDR_W'(prev_q) << 1);
	assign next3 = VADDR_W'(next_q) + (VADDR_W'(next_q) << 1);
	assign prev9 = VADDR_W'(prev_q) + (VADDR_W'(prev_q) << 3);
	assign next9 = VADDR_W'(next_q) + (VADDR_W'(next_q) << 3);
	assign cext  = VADDR_W'(comp_q);

	always_comb begin
		case (term.addr)
			AD_P3:   value_raddr = prev3 + cext;
			AD_N3:   value_raddr = next3 + cext;
			AD_TIN:  value_raddr = next9 + cext;
			AD_TOUT: value_raddr = prev9 + VADDR_W'(6) + cext;
			AD_V0:   value_raddr = prev9 + VADDR_W'(3) + cext;
			AD_V1:   value_raddr = next9 + VADDR_W'(3) + cext;
			default: value_raddr = prev3 + cext;
		endcase
	end

	always_comb begin
		case (term.src)
			OP_MEM:  opnd = $signed(values_rdata_q);
			OP_A:    opnd = a_q;
			OP_B:    opnd = b_q;
			OP_S:    opnd = s_q;
			OP_CUR:  opnd = cur_q[comp_q];
			default: opnd = cur_q[comp_q];
		endcase
	end

	always_comb begin
		case (term.coef)
			CF_ONE:   coef = $signed(COEF_W'(TN_ONE));
			CF_OMT:   coef = $signed(COEF_W'(TN_ONE - tn_q));
			CF_TN:    coef = $signed(COEF_W'(tn_q));
			CF_DELTA: coef = COEF_W'(delta_q);
			CF_H00:   coef = COEF_W'(h00_q);
			CF_H10:   coef = COEF_W'(h10_q);
			CF_H01:   coef = COEF_W'(h01_q);
			CF_H11:   coef = COEF_W'(h11_q);
			CF_OMW:   coef = $signed(COEF_W'(TN_ONE - w_eff));
			CF_W:     coef = $signed(COEF_W'(w_eff));
			default:  coef = $signed(COEF_W'(TN_ONE));
		endcase
	end

	// the shared multiplier: powers of tn first, then the term products
	always_comb begin
		case (state_q)
			ST_SQ: begin
				mul_a = $signed(DATA_W'(tn_q));
				mul_b = $signed(COEF_W'(tn_q));
			end
			ST_CU: begin
				mul_a = $signed(DATA_W'(t2_q));
				mul_b = $signed(COEF_W'(tn_q));
			end
			default: begin
				mul_a = opnd;
				mul_b = coef;
			end
		endcase
	end
	assign prod = mul_a * mul_b;

	assign acc_sum = acc_q + ACC_W'(prod_q);
	assign acc_rs  = rsat(acc_sum);

	assign e1 = $signed(H_W'(tn_q));
	assign e2 = $signed(H_W'(t2_q));
	assign e3 = $signed(H_W'(t3_q));

	// stores: written on the accepting beat, read data registered
	always_ff @(posedge clk) begin
		if (accept && (action == ACT_KEY_TIME))
			key_times_mem[key_index] <= write_value;
		times_rdata_q <= key_times_mem[time_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && (action == ACT_KEY_VALUE) && (word_address < VADDR_W'(VAL_WORDS)))
			key_values_mem[word_address] <= write_value;
		values_rdata_q <= key_values_mem[value_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= KCNT_W'(1);
			mode_q      <= MODE_LINEAR;
			blend_q     <= CFG_W'(TN_ONE);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_COUNT:    key_count_q <= cfg_data[KCNT_W-1:0];
				REG_INTERP_MODE:  mode_q      <= mode_t'(cfg_data[1:0]);
				REG_BLEND_AMOUNT: blend_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			sv_q        <= 1'b0;
			step_q      <= '0;
			comp_q      <= '0;
			pend_q      <= 1'b0;
			pend_dest_q <= DS_NONE;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (action == ACT_SAMPLE)) state_q <= ST_RD0;
				end
				ST_RD0:   state_q <= ST_RDL;
				ST_RDL:   state_q <= ST_CLAMP;
				ST_CLAMP: begin
					k_q     <= '0;
					sv_q    <= 1'b0;
					state_q <= ST_SRCH;
				end
				ST_SRCH: begin
					if (hit || (!sv_q && (k_q == n_keys))) begin
						state_q <= ST_RDP;
					end else if (k_q < n_keys) begin
						k_q  <= k_q + 1'b1;
						sv_q <= 1'b1;
					end else begin
						sv_q <= 1'b0;
					end
				end
				ST_RDP:   state_q <= ST_RDN;
				ST_RDN:   state_q <= ST_DELTA;
				ST_DELTA: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) state_q <= ST_SQ;
				end
				ST_SQ:    state_q <= ST_SQR;
				ST_SQR:   state_q <= ST_CU;
				ST_CU:    state_q <= ST_CUR;
				ST_CUR:   state_q <= ST_HERM;
				ST_HERM: begin
					comp_q  <= '0;
					step_q  <= '0;
					pend_q  <= 1'b0;
					state_q <= ST_TA;
				end
				ST_TA:    state_q <= ST_TB;
				ST_TB: begin
					pend_q      <= 1'b1;
					pend_dest_q <= term.dest;
					if (term.last) begin
						state_q <= ST_FLUSH;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_TA;
					end
				end
				ST_FLUSH: begin
					pend_q <= 1'b0;
					step_q <= '0;
					if (comp_q == 2'd2) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= ST_TA;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q      <= sample_time;
			cur_q[0] <= current_x;
			cur_q[1] <= current_y;
			cur_q[2] <= current_z;
		end
		case (state_q)
			ST_RDL: t0_q <= trd;
			ST_CLAMP: begin
				// raise to the first key time first, else lower to the last
				if (t_q < t0_q) tc_q <= t0_q;
				else if (t_q > trd) tc_q <= trd;
				else tc_q <= t_q;
			end
			ST_SRCH: begin
				if (hit) begin
					if (n_keys == KCNT_W'(1)) begin
						next_q <= '0;
						prev_q <= '0;
					end else begin
						next_q <= nx_hit;
						prev_q <= nx_hit - 1'b1;
					end
				end else if (!sv_q && (k_q == n_keys)) begin
					// no key at or after the time
					next_q <= '0;
					prev_q <= '0;
				end
				if (k_q < n_keys) si_q <= k_q[KIDX_W-1:0];
			end
			ST_RDN: tprev_q <= trd;
			ST_DELTA: begin
				delta_q <= dden;
				tn_q    <= tz ? '0 : TN_ONE;
			end
			ST_DIV: begin
				if (div_done && (tn_q != '0)) tn_q <= div_quo;
			end
			ST_SQ:  prod_q <= prod;
			ST_SQR: t2_q   <= TN_W'(acc_rs_of(prod_q));
			ST_CU:  prod_q <= prod;
			ST_CUR: t3_q   <= TN_W'(acc_rs_of(prod_q));
			ST_HERM: begin
				h00_q <= (e3 <<< 1) - (e2 + (e2 <<< 1)) + $signed(H_W'(TN_ONE));
				h10_q <= e3 - (e2 <<< 1) + e1;
				h01_q <= (e2 + (e2 <<< 1)) - (e3 <<< 1);
				h11_q <= e3 - e2;
				acc_q <= '0;
			end
			ST_TA: begin
				if (pend_q) begin
					if (pend_dest_q == DS_NONE) begin
						acc_q <= acc_sum;
					end else begin
						acc_q <= '0;
						case (pend_dest_q)
							DS_A:    a_q <= acc_rs;
							DS_B:    b_q <= acc_rs;
							DS_S:    s_q <= acc_rs;
							default: ;
						endcase
					end
				end
			end
			ST_TB: prod_q <= prod;
			ST_FLUSH: begin
				res_q[comp_q] <= acc_rs;
				acc_q         <= '0;
			end
			default: ;
		endcase
	end

	// result strobe follows the last flush only
	a_done_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FLUSH))
		else $error("result strobe without a final flush");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its wait state");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_SAMPLE)) |=> busy)
		else $error("sample beat did not raise busy");

endmodule
